// File: src/hdu_pkg.sv
// Shared types and constants for the Huffman tree-walk decoder.
package hdu_pkg;

	localparam int IDX_W     = 9;
	localparam int SYM_W     = 8;
	localparam int NBITS_W   = 4;
	localparam int BYTE_BITS = 8;
	localparam int TOP_BIT   = 7;
	localparam int QDEPTH    = 4;

	typedef enum logic {
		REQ_LOAD   = 1'b0,
		REQ_DECODE = 1'b1
	} req_kind_t;

	typedef struct packed {
		logic [IDX_W-1:0] left;
		logic [IDX_W-1:0] right;
		logic             leaf;
		logic [SYM_W-1:0] sym;
	} node_t;

	typedef struct packed {
		req_kind_t          kind;
		logic [IDX_W-1:0]   idx;
		node_t              node;
		logic [7:0]         data;
		logic [NBITS_W-1:0] nbits;
	} req_t;

endpackage

// File: src/hdu_front.sv
// Front end: accept input requests, classify them and hand them to the queue.
module hdu_front #(
	parameter int TREE_NODES = 511
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [47:0]               s_tdata,
	input  logic [0:0]                s_tuser,
	output logic                      q_push,
	output hdu_pkg::req_t             q_req,
	input  logic                      q_full
);
	import hdu_pkg::*;

	logic               v_s1;
	req_t               req_s1;
	req_t               req_in;
	logic               keep;
	logic [NBITS_W-1:0] nbits_raw;

	always_comb begin
		nbits_raw        = s_tdata[47:44];
		req_in.kind      = s_tuser[0] ? REQ_DECODE : REQ_LOAD;
		req_in.idx       = s_tdata[8:0];
		req_in.node.left = s_tdata[17:9];
		req_in.node.right = s_tdata[26:18];
		req_in.node.leaf = s_tdata[27];
		req_in.node.sym  = s_tdata[35:28];
		req_in.data      = s_tdata[43:36];
		// clamp oversized bit counts to a whole byte
		req_in.nbits     = (nbits_raw > NBITS_W'(BYTE_BITS)) ? NBITS_W'(BYTE_BITS) : nbits_raw;
		// drop loads beyond the node memory and decodes with no bits
		if (req_in.kind == REQ_LOAD) begin
			keep = (req_in.idx < IDX_W'(TREE_NODES));
		end else begin
			keep = (nbits_raw != '0);
		end
	end

	assign s_tready = !v_s1 || !q_full;
	assign q_push   = v_s1 && !q_full;
	assign q_req    = req_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			v_s1 <= keep;
		end else if (q_push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1 <= req_in;
		end
	end

endmodule

// File: src/hdu_fifo.sv
// Short request queue between the front end and the tree walker.
module hdu_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hdu_pkg::req_t din,
	output logic          full,
	input  logic          pop,
	output hdu_pkg::req_t dout,
	output logic          empty
);
	import hdu_pkg::*;

	localparam int PW = $clog2(QDEPTH);
	localparam int CW = $clog2(QDEPTH + 1);

	req_t          mem_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == CW'(QDEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QDEPTH))
		else $error("request queue count overflow");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("request pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("request popped from an empty queue");

endmodule

// File: src/hdu_back.sv
// Back end: node memory, tree walk and the result register.
module hdu_back #(
	parameter int TREE_NODES = 511
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wen,
	input  logic [hdu_pkg::IDX_W-1:0]   cfg_wdata,
	input  logic                        q_empty,
	input  hdu_pkg::req_t               q_req,
	output logic                        q_pop,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [7:0]                  m_tdata,
	output logic                        m_tlast
);
	import hdu_pkg::*;

	localparam int AW = $clog2(TREE_NODES);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FIRST,
		ST_WALK,
		ST_FLUSH
	} state_t;

	node_t              mem_q [TREE_NODES];
	state_t             st_q;
	logic [IDX_W-1:0]   root_q;
	logic [IDX_W-1:0]   pos_q;
	logic [7:0]         byte_q;
	logic [NBITS_W-1:0] cnt_q;
	logic               pend_v_q;
	logic [SYM_W-1:0]   pend_sym_q;
	logic               out_v_q;
	logic [SYM_W-1:0]   out_sym_q;
	logic               out_last_q;
	node_t              rda_q;
	node_t              rdb_q;
	logic               oob_a_q;
	logic               oob_b_q;

	node_t            a_node;
	node_t            b_node;
	node_t            eff;
	logic [IDX_W-1:0] child;
	logic [IDX_W-1:0] addr_a;
	logic             hit_leaf;
	logic             need_push;
	logic             out_free;
	logic             stall;
	logic             push;
	logic             wr_en;

	// nodes outside the memory read as all zero
	assign a_node   = oob_a_q ? '0 : rda_q;
	assign b_node   = oob_b_q ? '0 : rdb_q;
	assign hit_leaf = (st_q == ST_WALK) && a_node.leaf;
	assign eff      = hit_leaf ? b_node : a_node;
	assign child    = byte_q[TOP_BIT] ? eff.right : eff.left;
	assign addr_a   = ((st_q == ST_FIRST) || ((st_q == ST_WALK) && (cnt_q != '0))) ?
		child : pos_q;

	assign need_push = pend_v_q && (hit_leaf || (st_q == ST_FLUSH));
	assign out_free  = !out_v_q || m_tready;
	assign stall     = need_push && !out_free;
	assign push      = need_push && out_free;

	assign q_pop = (st_q == ST_IDLE) && !q_empty;
	assign wr_en = q_pop && (q_req.kind == REQ_LOAD);

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_sym_q;
	assign m_tlast  = out_last_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[q_req.idx[AW-1:0]] <= q_req.node;
		end
		if (!stall) begin
			rda_q   <= mem_q[addr_a[AW-1:0]];
			oob_a_q <= (addr_a >= IDX_W'(TREE_NODES));
		end
		rdb_q   <= mem_q[root_q[AW-1:0]];
		oob_b_q <= (root_q >= IDX_W'(TREE_NODES));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			root_q     <= '0;
			pos_q      <= '0;
			cnt_q      <= '0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
			out_sym_q  <= '0;
			out_last_q <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (q_pop && (q_req.kind == REQ_DECODE)) begin
						byte_q <= q_req.data;
						cnt_q  <= q_req.nbits;
						st_q   <= ST_FIRST;
					end
				end
				ST_FIRST: begin
					pos_q  <= child;
					byte_q <= byte_q << 1;
					cnt_q  <= cnt_q - 1'b1;
					st_q   <= ST_WALK;
				end
				ST_WALK: begin
					if (!stall) begin
						if (hit_leaf) begin
							pend_v_q   <= 1'b1;
							pend_sym_q <= a_node.sym;
						end
						if (cnt_q != '0) begin
							pos_q  <= child;
							byte_q <= byte_q << 1;
							cnt_q  <= cnt_q - 1'b1;
						end else begin
							if (hit_leaf) begin
								pos_q <= root_q;
							end
							st_q <= ST_FLUSH;
						end
					end
				end
				ST_FLUSH: begin
					if (!stall) begin
						pend_v_q <= 1'b0;
						st_q     <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
			if (cfg_wen) begin
				root_q <= cfg_wdata;
				pos_q  <= cfg_wdata;
			end
			if (push) begin
				out_v_q    <= 1'b1;
				out_sym_q  <= pend_sym_q;
				out_last_q <= (st_q == ST_FLUSH);
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE) |-> !pend_v_q)
		else $error("symbol left pending between bytes");

	a_first_to_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_FIRST) |=> (st_q == ST_WALK))
		else $error("first fetch did not advance to walk");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> $stable(cnt_q) && $stable(byte_q))
		else $error("walk advanced while result register was blocked");

endmodule

// File: src/huffman_tree_decoder_unit.sv
// Top level of the Huffman tree-walk decoder: front end, request queue and walker.
//
//  channel  | direction | payload (low bit first)                         | done when
//  ---------+-----------+-------------------------------------------------+------------------
//  s_*      | in        | tuser: command; tdata: node, children, leaf,    | tvalid & tready
//           |           |   symbol, data byte, valid bits                 |
//  m_*      | out       | tdata: symbol; tlast: last symbol of the byte   | tvalid & tready
//  cfg_*    | in        | cfg_wdata: root index                           | cfg_wen
//
// A load request is written into the node memory as the walker pops it. A decode
// request passes through the walker in order: pop, fetch of the current node, one
// step per bit, release of the final symbol. The bit loop runs through the node
// memory read port, one child read per bit. The front end and the four-entry
// queue keep accepting while the walker works. arst_n clears control state; the
// node memory is not cleared and must be loaded before use. The walker stalls
// only while a symbol has to move into the result register and that register
// still holds an unaccepted result.
module huffman_tree_decoder_unit #(
	parameter int TREE_NODES = 511
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wen,
	input  logic [hdu_pkg::IDX_W-1:0] cfg_wdata,   // root_index
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// node_index[8:0], left_child[17:9], right_child[26:18], leaf_flag[27],
	// leaf_symbol[35:28], data_byte[43:36], valid_bits[47:44]
	input  logic [47:0]               s_tdata,
	input  logic [0:0]                s_tuser,     // command
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [7:0]                m_tdata,     // out_symbol
	output logic                      m_tlast      // last_of_run
);
	import hdu_pkg::*;

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	req_t q_in;
	req_t q_out;

	// classify requests, drop those with no effect
	hdu_front #(
		.TREE_NODES(TREE_NODES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_push   (q_push),
		.q_req    (q_in),
		.q_full   (q_full)
	);

	// decouple acceptance from the bit-serial walk
	hdu_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_in),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_out),
		.empty  (q_empty)
	);

	// hold the tree, walk it and emit symbols
	hdu_back #(
		.TREE_NODES(TREE_NODES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.q_empty   (q_empty),
		.q_req     (q_out),
		.q_pop     (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
